// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CpW  = 21;
    localparam int ByteW = 8;

    // Configuration register indexes.
    localparam logic CFG_REPLACEMENT = 1'b0;
    localparam logic CFG_LIMIT       = 1'b1;

    localparam logic [CpW-1:0] REPLACEMENT_RESET = 21'h00FFFD;
    localparam logic [CpW-1:0] LIMIT_RESET       = 21'h10FFFF;

    // Sequence tracking state.
    typedef struct packed {
        logic [2:0]     seq_len;
        logic [1:0]     remaining;
        logic [CpW-1:0] partial;
    } t_dec_state;

    // Results caused by one byte: a number of flushed replacements followed
    // by at most one result of the byte itself.
    typedef struct packed {
        logic [1:0]     flush_cnt;
        logic           has_tail;
        logic [CpW-1:0] tail_cp;
        logic           tail_rep;
    } t_bundle;

endpackage

// ===== rtl/utf8_byte_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// Decodes a UTF-8 byte stream into code points, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes one raw byte per transaction; a zero byte ends
//   the string and produces no result of its own. The m_axis channel gives
//   one code point per transaction with tuser set for a replacement and
//   tlast set on the final result caused by an input byte.
//   The cfg channel writes the replacement value (index 0) and the code point
//   limit (index 1); always ready. Users must write it while idle; not enforced.
// Latency and throughput:
//   A byte is decoded in the cycle it is accepted and its results appear on
//   m_axis on the next cycle. Sequence state updates at acceptance, so while
//   m_axis_tready is high a byte that gives zero or one result is taken every
//   cycle. A byte that breaks a pending sequence gives up to four results; they
//   leave the result register one per cycle while m_axis_tready is high, and the
//   next byte is accepted in the cycle the last of them is taken.
// Reset and stalls:
//   Reset clears any pending sequence and restores both registers to their
//   defaults. When the receiver holds m_axis_tready low, the result register
//   holds and s_axis_tready stays low until the results drain.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,   // [0] is_replacement
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [20:0] i_cfg_data
);

    utf8d_pkg::t_dec_state      r_state;
    utf8d_pkg::t_dec_state      n_state;
    utf8d_pkg::t_bundle         dec_bundle;
    logic [utf8d_pkg::CpW-1:0]  r_rep_value;
    logic [utf8d_pkg::CpW-1:0]  r_limit;
    logic [1:0]                 r_flush_cnt;
    logic                       r_has_tail;
    logic [utf8d_pkg::CpW-1:0]  r_tail_cp;
    logic                       r_tail_rep;
    logic                       busy;
    logic                       in_acc;
    logic                       out_acc;

    utf8d_decode u_decode (
        .i_state     (r_state),
        .i_byte      (s_axis_tdata),
        .i_rep_value (r_rep_value),
        .i_limit     (r_limit),
        .o_state     (n_state),
        .o_bundle    (dec_bundle)
    );

    assign busy          = (r_flush_cnt != 2'd0) || r_has_tail;
    assign m_axis_tvalid = busy;
    assign m_axis_tlast  = (r_flush_cnt == 2'd0) || (r_flush_cnt == 2'd1 && !r_has_tail);
    assign m_axis_tdata  = {3'b000, (r_flush_cnt != 2'd0) ? r_rep_value : r_tail_cp};
    assign m_axis_tuser  = (r_flush_cnt != 2'd0) ? 1'b1 : r_tail_rep;
    assign out_acc       = busy && m_axis_tready;
    // A new byte may enter while its predecessor's final result leaves.
    assign s_axis_tready = !busy || (out_acc && m_axis_tlast);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_rep_value <= utf8d_pkg::REPLACEMENT_RESET;
            r_limit     <= utf8d_pkg::LIMIT_RESET;
            r_flush_cnt <= 2'd0;
            r_has_tail  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    utf8d_pkg::CFG_REPLACEMENT: r_rep_value <= i_cfg_data;
                    utf8d_pkg::CFG_LIMIT:       r_limit     <= i_cfg_data;
                    default:                    r_limit     <= r_limit;
                endcase
            end
            if (in_acc) begin
                r_state     <= n_state;
                r_flush_cnt <= dec_bundle.flush_cnt;
                r_has_tail  <= dec_bundle.has_tail;
            end else if (out_acc) begin
                if (r_flush_cnt != 2'd0) begin
                    r_flush_cnt <= r_flush_cnt - 2'd1;
                end else begin
                    r_has_tail <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tail_cp  <= dec_bundle.tail_cp;
            r_tail_rep <= dec_bundle.tail_rep;
        end
    end

    // A sequence is pending exactly when a length is recorded.
    a_state_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.remaining == 2'd0) == (r_state.seq_len == 3'd0))
        else $error("sequence length and remaining count disagree");

    // While pending, at least the lead byte has been consumed.
    a_seq_exceeds_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.remaining != 2'd0) |-> (r_state.seq_len > {1'b0, r_state.remaining}))
        else $error("pending sequence shorter than remaining count");

    // The final continuation byte yields a decoded result and closes the sequence.
    a_completion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.remaining == 2'd1 && s_axis_tdata[7:6] == 2'b10)
        |=> (r_state.remaining == 2'd0 && r_has_tail && r_flush_cnt == 2'd0))
        else $error("completed sequence gave no result");

    // A byte accepted while results wait must coincide with the last one leaving.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && busy) |-> (out_acc && m_axis_tlast))
        else $error("result bundle overwritten before it drained");

endmodule

// ===== rtl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Combinational step of the decoder: next sequence state and result bundle.
// ----------------------------------------------------------------------------
module utf8d_decode (
    input  utf8d_pkg::t_dec_state           i_state,
    input  logic [utf8d_pkg::ByteW-1:0]     i_byte,
    input  logic [utf8d_pkg::CpW-1:0]       i_rep_value,
    input  logic [utf8d_pkg::CpW-1:0]       i_limit,
    output utf8d_pkg::t_dec_state           o_state,
    output utf8d_pkg::t_bundle              o_bundle
);

    logic                        pending;
    logic                        is_cont;
    logic [utf8d_pkg::CpW-1:0]   acc_cp;
    logic [1:0]                  rem_dec;
    logic [2:0]                  consumed;
    logic [utf8d_pkg::CpW-1:0]   ascii_cp;

    assign pending  = (i_state.remaining != 2'd0);
    assign is_cont  = (i_byte[7:6] == 2'b10);
    assign acc_cp   = {i_state.partial[utf8d_pkg::CpW-7:0], i_byte[5:0]};
    assign rem_dec  = i_state.remaining - 2'd1;
    assign ascii_cp = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, i_byte};

    // Bytes of the broken sequence taken so far, at least one and at most three.
    always_comb begin
        if (i_state.seq_len > {1'b0, i_state.remaining}) begin
            consumed = i_state.seq_len - {1'b0, i_state.remaining};
        end else begin
            consumed = 3'd1;
        end
        if (consumed > 3'd3) begin
            consumed = 3'd3;
        end
    end

    always_comb begin
        o_state           = '0;
        o_bundle          = '0;
        o_bundle.tail_cp  = i_rep_value;
        o_bundle.tail_rep = 1'b1;
        if (pending && is_cont) begin
            o_state.seq_len   = i_state.seq_len;
            o_state.remaining = rem_dec;
            o_state.partial   = acc_cp;
            if (rem_dec == 2'd0) begin
                o_state          = '0;
                o_bundle.has_tail = 1'b1;
                if (acc_cp <= i_limit) begin
                    o_bundle.tail_cp  = acc_cp;
                    o_bundle.tail_rep = 1'b0;
                end
            end
        end else begin
            if (pending) begin
                o_bundle.flush_cnt = consumed[1:0];
            end
            // The breaking byte, or any byte with nothing pending, starts afresh.
            if (i_byte == 8'h00) begin
                o_bundle.has_tail = 1'b0;
            end else if (is_cont) begin
                o_bundle.has_tail = 1'b1;
            end else if (!i_byte[7]) begin
                o_bundle.has_tail = 1'b1;
                if (ascii_cp <= i_limit) begin
                    o_bundle.tail_cp  = ascii_cp;
                    o_bundle.tail_rep = 1'b0;
                end
            end else if (i_byte == 8'hC0 || i_byte == 8'hC1 || i_byte >= 8'hF5) begin
                o_bundle.has_tail = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                o_state.seq_len   = 3'd2;
                o_state.remaining = 2'd1;
                o_state.partial   = {{(utf8d_pkg::CpW-5){1'b0}}, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                o_state.seq_len   = 3'd3;
                o_state.remaining = 2'd2;
                o_state.partial   = {{(utf8d_pkg::CpW-4){1'b0}}, i_byte[3:0]};
            end else begin
                o_state.seq_len   = 3'd4;
                o_state.remaining = 2'd3;
                o_state.partial   = {{(utf8d_pkg::CpW-3){1'b0}}, i_byte[2:0]};
            end
        end
    end

endmodule
